// ===== rtl/pdu_pkg.sv =====
// ---------------------------------------------------------------------------
// pdu_pkg: shared types and constants of the particle dimension update unit
// Field widths, register indexes, register reset values and the rounding shift.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pdu_pkg;

    localparam int COORD_W  = 32;   // Q16.16 coordinates and velocities
    localparam int WEIGHT_W = 16;   // Q4.12 weights
    localparam int RAND_W   = 16;   // Q0.16 random fractions
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 32;

    localparam int IN_TDATA_W  = 4 * COORD_W + 2 * RAND_W;
    localparam int OUT_TDATA_W = 2 * COORD_W;

    typedef enum logic [CFG_AW-1:0] {
        CFG_INERTIA   = 3'd0,
        CFG_COGNITIVE = 3'd1,
        CFG_SOCIAL    = 3'd2,
        CFG_POS_MIN   = 3'd3,
        CFG_POS_MAX   = 3'd4,
        CFG_VEL_MIN   = 3'd5,
        CFG_VEL_MAX   = 3'd6
    } t_cfg_reg;

    localparam logic [WEIGHT_W-1:0] RST_INERTIA   = 16'd2867;
    localparam logic [WEIGHT_W-1:0] RST_COGNITIVE = 16'd6144;
    localparam logic [WEIGHT_W-1:0] RST_SOCIAL    = 16'd6144;
    localparam logic [COORD_W-1:0]  RST_BOUND_MIN = 32'h8000_0000;
    localparam logic [COORD_W-1:0]  RST_BOUND_MAX = 32'h7FFF_FFFF;

    // Shift for the Q.36 to Q16.16 reduction (the rounding offset is half an output LSB).
    localparam int ROUND_SHIFT = 20;

endpackage

// ===== rtl/pso_particle_dimension_update_unit.sv =====
// ---------------------------------------------------------------------------
// pso_particle_dimension_update_unit
// Fixed-point particle swarm update of one dimension of one particle.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Payload
//  --------  ---------  -------------------------  ----------------------------------
//  s (in)    slave      i_s_tvalid / o_s_tready    i_s_tdata: position, velocity,
//                                                  own best, swarm best, r1, r2
//  m (out)   master     o_m_tvalid / i_m_tready    o_m_tdata: new position, velocity
//                                                  o_m_tuser: bounced
//  cfg       slave      i_cfg_valid / o_cfg_ready  i_cfg_addr, i_cfg_data
//
//  One item is taken every cycle while the output is drained. The five-stage
//  datapath's deepest stages are the 25x34 pull multipliers and the 60-bit
//  three-operand sum.
//  Synchronous active-low reset clears the valid bits and loads the register
//  defaults. A stall on the output freezes every stage at once, so nothing is
//  dropped or repeated; o_s_tready follows the free state of the output slot.
//
//  Datapath:
//   stage 1: x1 = x + v, c*r1 and s*r2 (floored to Q4.20), w*v
//   stage 2: pull differences, bounce test, position clamp
//   stage 3: pull products (Q.36)
//   stage 4: sum and round half up to Q16.16
//   stage 5: negate on bounce, velocity clamp (output register)
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pso_particle_dimension_update_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // cfg write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pdu_pkg::CFG_AW-1:0]      i_cfg_addr,
    input  logic [pdu_pkg::CFG_DW-1:0]      i_cfg_data,
    // input stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [31:0] cur_position, [63:32] cur_velocity, [95:64] own_best,
    // [127:96] swarm_best, [143:128] rand_cognitive, [159:144] rand_social
    input  logic [pdu_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // output stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [31:0] new_position, [63:32] new_velocity
    output logic [pdu_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    // [0] bounced
    output logic                            o_m_tuser
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic        [15:0] r_cfg_w;
    logic        [15:0] r_cfg_c;
    logic        [15:0] r_cfg_s;
    logic signed [31:0] r_cfg_pmin;
    logic signed [31:0] r_cfg_pmax;
    logic signed [31:0] r_cfg_vmin;
    logic signed [31:0] r_cfg_vmax;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w    <= pdu_pkg::RST_INERTIA;
            r_cfg_c    <= pdu_pkg::RST_COGNITIVE;
            r_cfg_s    <= pdu_pkg::RST_SOCIAL;
            r_cfg_pmin <= pdu_pkg::RST_BOUND_MIN;
            r_cfg_pmax <= pdu_pkg::RST_BOUND_MAX;
            r_cfg_vmin <= pdu_pkg::RST_BOUND_MIN;
            r_cfg_vmax <= pdu_pkg::RST_BOUND_MAX;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (pdu_pkg::t_cfg_reg'(i_cfg_addr))
                pdu_pkg::CFG_INERTIA:   r_cfg_w    <= i_cfg_data[15:0];
                pdu_pkg::CFG_COGNITIVE: r_cfg_c    <= i_cfg_data[15:0];
                pdu_pkg::CFG_SOCIAL:    r_cfg_s    <= i_cfg_data[15:0];
                pdu_pkg::CFG_POS_MIN:   r_cfg_pmin <= i_cfg_data;
                pdu_pkg::CFG_POS_MAX:   r_cfg_pmax <= i_cfg_data;
                pdu_pkg::CFG_VEL_MIN:   r_cfg_vmin <= i_cfg_data;
                pdu_pkg::CFG_VEL_MAX:   r_cfg_vmax <= i_cfg_data;
                default: ;  // unknown index: drop the write
            endcase
        end
    end

    // Order each bound pair: the lesser register acts as the minimum.
    logic signed [31:0] pos_lo, pos_hi, vel_lo, vel_hi;
    always_comb begin
        pos_lo = (r_cfg_pmin < r_cfg_pmax) ? r_cfg_pmin : r_cfg_pmax;
        pos_hi = (r_cfg_pmin < r_cfg_pmax) ? r_cfg_pmax : r_cfg_pmin;
        vel_lo = (r_cfg_vmin < r_cfg_vmax) ? r_cfg_vmin : r_cfg_vmax;
        vel_hi = (r_cfg_vmin < r_cfg_vmax) ? r_cfg_vmax : r_cfg_vmin;
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage advances when the output slot frees
    // ------------------------------------------------------------------
    logic adv;
    assign adv        = !o_m_tvalid || i_m_tready;
    assign o_s_tready = adv;

    logic r1_valid, r2_valid, r3_valid, r4_valid, r5_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else if (adv) begin
            r1_valid <= i_s_tvalid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: move position, scale random fractions, inertia product
    // ------------------------------------------------------------------
    logic signed [31:0] in_x, in_v, in_pb, in_gb;
    logic        [15:0] in_r1, in_r2;
    logic signed [32:0] n1_x1;
    logic        [31:0] cr_full, sr_full;
    logic signed [48:0] wv_full;

    always_comb begin
        in_x    = i_s_tdata[31:0];
        in_v    = i_s_tdata[63:32];
        in_pb   = i_s_tdata[95:64];
        in_gb   = i_s_tdata[127:96];
        in_r1   = i_s_tdata[143:128];
        in_r2   = i_s_tdata[159:144];
        n1_x1   = {in_x[31], in_x} + {in_v[31], in_v};
        cr_full = r_cfg_c * in_r1;
        sr_full = r_cfg_s * in_r2;
        wv_full = $signed({1'b0, r_cfg_w}) * in_v;
    end

    logic signed [32:0] r1_x1;
    logic signed [31:0] r1_pb, r1_gb;
    logic        [23:0] r1_cr, r1_sr;
    logic signed [47:0] r1_wv;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_x1 <= n1_x1;
            r1_pb <= in_pb;
            r1_gb <= in_gb;
            r1_cr <= cr_full[31:8];   // floor Q4.28 to Q4.20
            r1_sr <= sr_full[31:8];
            r1_wv <= wv_full[47:0];   // |w*v| < 2^47
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: pull differences, bounce test, clamp position
    // ------------------------------------------------------------------
    logic signed [32:0] pos_lo_x, pos_hi_x;
    logic               below, above;
    logic signed [33:0] n2_dp, n2_dg;
    logic signed [31:0] n2_pos;

    always_comb begin
        pos_lo_x = {pos_lo[31], pos_lo};
        pos_hi_x = {pos_hi[31], pos_hi};
        below    = r1_x1 < pos_lo_x;
        above    = r1_x1 > pos_hi_x;
        n2_dp    = {{2{r1_pb[31]}}, r1_pb} - {r1_x1[32], r1_x1};
        n2_dg    = {{2{r1_gb[31]}}, r1_gb} - {r1_x1[32], r1_x1};
        priority if (below) begin
            n2_pos = pos_lo;
        end else if (above) begin
            n2_pos = pos_hi;
        end else begin
            n2_pos = r1_x1[31:0];
        end
    end

    logic signed [33:0] r2_dp, r2_dg;
    logic        [23:0] r2_cr, r2_sr;
    logic signed [47:0] r2_wv;
    logic signed [31:0] r2_pos;
    logic               r2_oob;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_dp  <= n2_dp;
            r2_dg  <= n2_dg;
            r2_cr  <= r1_cr;
            r2_sr  <= r1_sr;
            r2_wv  <= r1_wv;
            r2_pos <= n2_pos;
            r2_oob <= below || above;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: pull products in Q.36
    // ------------------------------------------------------------------
    logic signed [58:0] n3_tp, n3_tg;

    always_comb begin
        n3_tp = $signed({1'b0, r2_cr}) * r2_dp;
        n3_tg = $signed({1'b0, r2_sr}) * r2_dg;
    end

    logic signed [58:0] r3_tp, r3_tg;
    logic signed [47:0] r3_wv;
    logic signed [31:0] r3_pos;
    logic               r3_oob;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_tp  <= n3_tp;
            r3_tg  <= n3_tg;
            r3_wv  <= r2_wv;
            r3_pos <= r2_pos;
            r3_oob <= r2_oob;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: sum, round half toward plus infinity, reduce to Q16.16
    // ------------------------------------------------------------------
    localparam logic signed [59:0] ROUND_HALF = 60'sd1 <<< (pdu_pkg::ROUND_SHIFT - 1);

    logic signed [59:0] acc;

    always_comb begin
        acc = {{4{r3_wv[47]}}, r3_wv, 8'd0}   // Q.28 shifted up to Q.36
            + {r3_tp[58], r3_tp}
            + {r3_tg[58], r3_tg}
            + ROUND_HALF;
    end

    logic signed [39:0] r4_v1;
    logic signed [31:0] r4_pos;
    logic               r4_oob;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_v1  <= acc[59:pdu_pkg::ROUND_SHIFT];   // floor by dropping bits
            r4_pos <= r3_pos;
            r4_oob <= r3_oob;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: negate on bounce, clamp velocity, hold for the output
    // ------------------------------------------------------------------
    logic signed [40:0] v_ext, v_sgn, vel_lo_x, vel_hi_x;
    logic signed [31:0] n5_vel;

    always_comb begin
        v_ext    = {r4_v1[39], r4_v1};
        v_sgn    = r4_oob ? -v_ext : v_ext;
        vel_lo_x = {{9{vel_lo[31]}}, vel_lo};
        vel_hi_x = {{9{vel_hi[31]}}, vel_hi};
        priority if (v_sgn < vel_lo_x) begin
            n5_vel = vel_lo;
        end else if (v_sgn > vel_hi_x) begin
            n5_vel = vel_hi;
        end else begin
            n5_vel = v_sgn[31:0];
        end
    end

    logic [31:0] r5_pos, r5_vel;
    logic        r5_oob;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_pos <= r4_pos;
            r5_vel <= n5_vel;
            r5_oob <= r4_oob;
        end
    end

    assign o_m_tvalid = r5_valid;
    assign o_m_tdata  = {r5_vel, r5_pos};
    assign o_m_tuser  = r5_oob;

endmodule

// ===== rtl/pdu_checker.sv =====
// ---------------------------------------------------------------------------
// pdu_checker: port-level checks of the particle dimension update unit
// Tracks items in flight and checks output stall behavior and occupancy.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pdu_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            i_s_tready,
    input logic                            i_m_tvalid,
    input logic                            i_m_tready,
    input logic [pdu_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    input logic                            i_m_tuser
);

    localparam int DEPTH = 5;

    logic       in_xfer, out_xfer;
    logic [2:0] r_count;

    assign in_xfer  = i_s_tvalid && i_s_tready;
    assign out_xfer = i_m_tvalid && i_m_tready;

    // Count items accepted but not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 3'd0;
        end else begin
            r_count <= r_count + 3'(in_xfer) - 3'(out_xfer);
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser))
        else $error("output changed while stalled");

    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'(DEPTH))
        else $error("more items in flight than pipeline stages");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> r_count != 3'd0)
        else $error("output valid with no item in flight");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == 3'(DEPTH) && i_m_tvalid && !i_m_tready |-> !i_s_tready)
        else $error("input taken while pipeline full and stalled");

endmodule

bind pso_particle_dimension_update_unit pdu_checker u_pdu_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser)
);
